FILE: src/tone_noise_sound_generator_unit_assert.svh
// Assertion macros shared by the checker of the tone/noise sound generator.
// Plain text macros only; taken in by `include where assertions are written.
`ifndef TONE_NOISE_SOUND_GENERATOR_UNIT_ASSERT_SVH
`define TONE_NOISE_SOUND_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define TNSG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tnsg assertion failed");

// Next-cycle implication, disabled while reset is low
`define TNSG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tnsg assertion failed");

`endif

FILE: src/tnsg_pkg.sv
// Shared types and constants of the tone/noise sound generator.
// No dependencies; imported by the interfaces, the design modules and the testbench.
`default_nettype none

package tnsg_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned PERIOD_BITS  = 12;
  localparam int unsigned NUM_REGS     = 16;
  localparam int unsigned REG_ADDR_W   = 4;
  localparam int unsigned LFSR_BITS    = 32;
  localparam int unsigned ADDR_BITS    = 16;
  localparam int unsigned MIX_BITS     = 10;

  // Item kinds (code 3 is unused and changes nothing)
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } tnsg_mode_e;

  // Register map
  localparam logic [REG_ADDR_W-1:0] REG_MASK       = 4'd8;
  localparam logic [REG_ADDR_W-1:0] REG_VOLUME     = 4'd9;
  localparam logic [REG_ADDR_W-1:0] REG_SAMPLE_CFG = 4'd10;
  localparam logic [REG_ADDR_W-1:0] REG_START_LO   = 4'd12;
  localparam logic [REG_ADDR_W-1:0] REG_START_HI   = 4'd13;
  localparam logic [REG_ADDR_W-1:0] REG_END_LO     = 4'd14;
  localparam logic [REG_ADDR_W-1:0] REG_END_HI     = 4'd15;

  // LFSR taps: tone channels use the long set, the last channel the short set
  localparam int unsigned TAP_L0 = 25;
  localparam int unsigned TAP_L1 = 19;
  localparam int unsigned TAP_L2 = 11;
  localparam int unsigned TAP_L3 = 9;
  localparam int unsigned TAP_S0 = 4;
  localparam int unsigned TAP_S1 = 3;
  localparam int unsigned TAP_S2 = 1;
  localparam int unsigned TAP_S3 = 0;

  // Decoded register contents used by the tick logic
  typedef struct packed {
    logic [NUM_CHANNELS-1:0][PERIOD_BITS-1:0] period;
    logic [7:0]                               mask;
    logic                                     playing;
    logic [ADDR_BITS-1:0]                     start_addr;
    logic [ADDR_BITS-1:0]                     end_addr;
  } tnsg_cfg_t;

  // Per-channel status after the current item
  typedef struct packed {
    logic sel;
    logic div;
    logic pulse;
  } tnsg_chan_t;

endpackage

`default_nettype wire

FILE: src/tnsg_in_if.sv
// Input channel of the sound generator: valid/ready plus one item.
// Depends on tnsg_pkg.
`default_nettype none

interface tnsg_in_if;
  import tnsg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [REG_ADDR_W-1:0] reg_addr;
  logic [7:0]            write_data;

  modport source (output valid, output mode, output reg_addr, output write_data,
                  input ready);
  modport sink   (input valid, input mode, input reg_addr, input write_data,
                  output ready);
endinterface

`default_nettype wire

FILE: src/tnsg_out_if.sv
// Result channel of the sound generator: valid/ready plus one result item.
// Depends on tnsg_pkg.
`default_nettype none

interface tnsg_out_if;
  import tnsg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NUM_CHANNELS-1:0] channel_bits;
  logic [NUM_CHANNELS-1:0] divided_bits;
  logic [NUM_CHANNELS-1:0] pulse_bits;
  logic [ADDR_BITS-1:0]    sample_address;
  logic [MIX_BITS-1:0]     mix_level;
  logic [7:0]              random_byte;
  logic [7:0]              read_data;

  modport source (output valid, output channel_bits, output divided_bits,
                  output pulse_bits, output sample_address, output mix_level,
                  output random_byte, output read_data, input ready);
  modport sink   (input valid, input channel_bits, input divided_bits,
                  input pulse_bits, input sample_address, input mix_level,
                  input random_byte, input read_data, output ready);
endinterface

`default_nettype wire

FILE: src/tone_noise_sound_generator_unit.sv
// Top level of the four-channel tone/noise sound generator.
// Depends on tnsg_pkg, tnsg_in_if, tnsg_out_if, tnsg_regs, tnsg_channel, tnsg_sample.
`default_nettype none

// Takes one item per clock (tick, register write or register read) when the
// output is not stalled, and returns one result item for each. An accepted item
// sits in an input register; when the output register is empty or being taken,
// the channel state, sample address and registers are updated and the result is
// loaded into the output register. The input register frees whenever the output
// register is empty or being taken, so the sustained rate is one item per cycle
// while the output is not stalled. All channels advance together on a tick; the
// longest path is the period compare and output select feeding the small
// count-times-volume multiply of the mix level. No clearing pass is needed after
// reset.

module tone_noise_sound_generator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tnsg_in_if.sink    in_item_i,
  tnsg_out_if.source out_item_o
);
  import tnsg_pkg::*;

  // Input stage
  logic                  in_valid_q;
  logic [1:0]            mode_q;
  logic [REG_ADDR_W-1:0] addr_q;
  logic [7:0]            data_q;

  // Output stage
  logic                    out_valid_q;
  logic [NUM_CHANNELS-1:0] chan_q, div_q, pulse_q;
  logic [ADDR_BITS-1:0]    saddr_q;
  logic [MIX_BITS-1:0]     mix_q, mix_d;
  logic [7:0]              rand_q;
  logic [7:0]              rdata_q, rdata_d;

  logic                    advance;
  logic                    tick;
  logic                    wr;
  tnsg_cfg_t               cfg;
  logic [7:0]              vol_d;
  logic [7:0]              rd_data;
  tnsg_chan_t              status [NUM_CHANNELS];
  logic [7:0]              lfsr_byte [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] sel_d, divb_d, pulseb_d;
  logic [ADDR_BITS-1:0]    saddr_d;
  logic [2:0]              bit_count;

  // Handshake: the input stage moves on when the output stage is free
  assign advance         = in_valid_q && (!out_valid_q || out_item_o.ready);
  assign in_item_i.ready = !in_valid_q || advance;
  assign tick            = advance && (mode_q == MODE_TICK);
  assign wr              = advance && (mode_q == MODE_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_item_i.ready) begin
      in_valid_q <= in_item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_item_i.valid && in_item_i.ready) begin
      mode_q <= in_item_i.mode;
      addr_q <= in_item_i.reg_addr;
      data_q <= in_item_i.write_data;
    end
  end

  tnsg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .write_i   (wr),
    .addr_i    (addr_q),
    .data_i    (data_q),
    .cfg_o     (cfg),
    .vol_d_o   (vol_d),
    .rd_data_o (rd_data)
  );

  tnsg_sample u_sample (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .cfg_i    (cfg),
    .addr_d_o (saddr_d)
  );

  // Channels; only the last one uses the short tap set
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    tnsg_channel u_channel (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tick_i       (tick),
      .short_taps_i (c == NUM_CHANNELS - 1),
      .period_i     (cfg.period[c]),
      .noise_sel_i  (cfg.mask[c + NUM_CHANNELS]),
      .div_sel_i    (cfg.mask[c]),
      .status_o     (status[c]),
      .lfsr_byte_o  (lfsr_byte[c])
    );
    assign sel_d[c]    = status[c].sel;
    assign divb_d[c]   = status[c].div;
    assign pulseb_d[c] = status[c].pulse;
  end

  // Mix level: set-bit count times volume
  always_comb begin
    bit_count = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      bit_count = bit_count + 3'(sel_d[c]);
    end
  end
  assign mix_d   = MIX_BITS'(bit_count) * MIX_BITS'(vol_d);
  assign rdata_d = (mode_q == MODE_READ) ? rd_data : 8'd0;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_item_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      chan_q  <= sel_d;
      div_q   <= divb_d;
      pulse_q <= pulseb_d;
      saddr_q <= saddr_d;
      mix_q   <= mix_d;
      rand_q  <= lfsr_byte[0];
      rdata_q <= rdata_d;
    end
  end

  assign out_item_o.valid          = out_valid_q;
  assign out_item_o.channel_bits   = chan_q;
  assign out_item_o.divided_bits   = div_q;
  assign out_item_o.pulse_bits     = pulse_q;
  assign out_item_o.sample_address = saddr_q;
  assign out_item_o.mix_level      = mix_q;
  assign out_item_o.random_byte    = rand_q;
  assign out_item_o.read_data      = rdata_q;

endmodule

`default_nettype wire

FILE: src/tnsg_regs.sv
// Sixteen byte registers: write port, one read port, decoded fields.
// Depends on tnsg_pkg.
`default_nettype none

module tnsg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           write_i,
  input  logic [tnsg_pkg::REG_ADDR_W-1:0] addr_i,
  input  logic [7:0]                     data_i,
  output tnsg_pkg::tnsg_cfg_t            cfg_o,
  output logic [7:0]                     vol_d_o,
  output logic [7:0]                     rd_data_o
);
  import tnsg_pkg::*;

  logic [NUM_REGS-1:0][7:0] reg_q;

  // Register file, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= '0;
    end else if (write_i) begin
      reg_q[addr_i] <= data_i;
    end
  end

  // Decode fields for the tick logic
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      cfg_o.period[c] = {reg_q[2*c+1][PERIOD_BITS-9:0], reg_q[2*c]};
    end
    cfg_o.mask       = reg_q[REG_MASK];
    cfg_o.playing    = reg_q[REG_SAMPLE_CFG][0];
    cfg_o.start_addr = {reg_q[REG_START_HI], reg_q[REG_START_LO]};
    cfg_o.end_addr   = {reg_q[REG_END_HI], reg_q[REG_END_LO]};
  end

  // Volume as it stands after this item, so a volume write shows at once
  assign vol_d_o   = (write_i && addr_i == REG_VOLUME) ? data_i : reg_q[REG_VOLUME];
  assign rd_data_o = reg_q[addr_i];

endmodule

`default_nettype wire

FILE: src/tnsg_channel.sv
// One tone/noise channel: period counter, divider, pulse, LFSR, output select.
// Depends on tnsg_pkg.
`default_nettype none

module tnsg_channel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic                            short_taps_i,
  input  logic [tnsg_pkg::PERIOD_BITS-1:0] period_i,
  input  logic                            noise_sel_i,
  input  logic                            div_sel_i,
  output tnsg_pkg::tnsg_chan_t            status_o,
  output logic [7:0]                      lfsr_byte_o
);
  import tnsg_pkg::*;

  logic [PERIOD_BITS-1:0] count_q, count_d;
  logic [LFSR_BITS-1:0]   lfsr_q, lfsr_d;
  logic                   div_q, div_d;
  logic                   pulse_q, pulse_d;
  logic                   sel_q, sel_d;
  logic                   fire;
  logic                   fb;

  // Fire when the count has reached a nonzero period
  assign fire = (period_i != '0) && (count_q >= period_i);

  // XNOR feedback, shifted in at the top
  assign fb = short_taps_i
            ? (lfsr_q[TAP_S0] ^ lfsr_q[TAP_S1] ^ lfsr_q[TAP_S2] ^ lfsr_q[TAP_S3])
            : (lfsr_q[TAP_L0] ^ lfsr_q[TAP_L1] ^ lfsr_q[TAP_L2] ^ lfsr_q[TAP_L3]);

  // Next state; holds unless a tick arrives
  always_comb begin
    count_d = count_q;
    lfsr_d  = lfsr_q;
    div_d   = div_q;
    pulse_d = pulse_q;
    sel_d   = sel_q;
    if (tick_i) begin
      count_d = fire ? '0 : count_q + PERIOD_BITS'(1);
      lfsr_d  = fire ? {~fb, lfsr_q[LFSR_BITS-1:1]} : lfsr_q;
      div_d   = div_q ^ fire;
      pulse_d = fire;
      if (noise_sel_i) begin
        sel_d = lfsr_d[0];
      end else if (div_sel_i) begin
        sel_d = div_d;
      end else begin
        sel_d = fire;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lfsr_q  <= '0;
      div_q   <= 1'b0;
      pulse_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      lfsr_q  <= lfsr_d;
      div_q   <= div_d;
      pulse_q <= pulse_d;
      sel_q   <= sel_d;
    end
  end

  assign status_o.sel   = sel_d;
  assign status_o.div   = div_d;
  assign status_o.pulse = pulse_d;
  assign lfsr_byte_o    = lfsr_d[7:0];

endmodule

`default_nettype wire

FILE: src/tnsg_sample.sv
// Sample playback address: runs from start to end while playing, else zero.
// Depends on tnsg_pkg.
`default_nettype none

module tnsg_sample (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  tnsg_pkg::tnsg_cfg_t           cfg_i,
  output logic [tnsg_pkg::ADDR_BITS-1:0] addr_d_o
);
  import tnsg_pkg::*;

  logic [ADDR_BITS-1:0] addr_q, addr_d, addr_inc;

  assign addr_inc = addr_q + ADDR_BITS'(1);

  // Step on ticks; wrap back to start past the end address
  always_comb begin
    addr_d = addr_q;
    if (tick_i) begin
      if (!cfg_i.playing) begin
        addr_d = '0;
      end else if (addr_inc > cfg_i.end_addr) begin
        addr_d = cfg_i.start_addr;
      end else begin
        addr_d = addr_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else begin
      addr_q <= addr_d;
    end
  end

  assign addr_d_o = addr_d;

endmodule

`default_nettype wire

FILE: src/tnsg_checker.sv
// Port-level checks on the result channel of the sound generator, and its bind.
// Depends on tone_noise_sound_generator_unit_assert.svh.
`default_nettype none

`include "tone_noise_sound_generator_unit_assert.svh"

module tnsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  channel_bits_i,
  input logic [3:0]  divided_bits_i,
  input logic [3:0]  pulse_bits_i,
  input logic [15:0] sample_address_i,
  input logic [9:0]  mix_level_i,
  input logic [7:0]  random_byte_i,
  input logic [7:0]  read_data_i
);

  // Silent channels give a silent mix
  `TNSG_ASSERT_IMP(a_mix_silent, clk_i, rst_ni, out_valid_i && channel_bits_i == 4'd0, mix_level_i == 10'd0)

  // Mix never exceeds full volume on each active channel
  `TNSG_ASSERT_IMP(a_mix_bound, clk_i, rst_ni, out_valid_i, mix_level_i <= 10'($countones(channel_bits_i)) * 10'd255)

  // A stalled result stays put
  `TNSG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({channel_bits_i, divided_bits_i, pulse_bits_i, sample_address_i, mix_level_i, random_byte_i, read_data_i}))

endmodule

bind tone_noise_sound_generator_unit tnsg_checker u_tnsg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_item_o.valid),
  .out_ready_i      (out_item_o.ready),
  .channel_bits_i   (out_item_o.channel_bits),
  .divided_bits_i   (out_item_o.divided_bits),
  .pulse_bits_i     (out_item_o.pulse_bits),
  .sample_address_i (out_item_o.sample_address),
  .mix_level_i      (out_item_o.mix_level),
  .random_byte_i    (out_item_o.random_byte),
  .read_data_i      (out_item_o.read_data)
);

`default_nettype wire

FILE: dv/tb_tone_noise_sound_generator_unit.sv
// Self-checking testbench for tone_noise_sound_generator_unit: directed and random
// tick/write/read items, with every result checked against an in-bench predictor.
// Depends on tnsg_pkg, tnsg_in_if, tnsg_out_if and the generator RTL.
`default_nettype none

module tb_tone_noise_sound_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tnsg_pkg::*;

  // Item kind 3 is not decoded by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Period registers and the sample pitch register, which have no name in the package
  localparam logic [REG_ADDR_W-1:0] REG_PERIOD_LO0   = 4'd0;
  localparam logic [REG_ADDR_W-1:0] REG_PERIOD_HI0   = 4'd1;
  localparam logic [REG_ADDR_W-1:0] REG_PERIOD_LO3   = 4'd6;
  localparam logic [REG_ADDR_W-1:0] REG_PERIOD_HI3   = 4'd7;
  localparam logic [REG_ADDR_W-1:0] REG_SAMPLE_PITCH = 4'd11;

  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned ITEMS_PER_PHASE  = 375;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] channel_bits;
    logic [NUM_CHANNELS-1:0] divided_bits;
    logic [NUM_CHANNELS-1:0] pulse_bits;
    logic [ADDR_BITS-1:0]    sample_address;
    logic [MIX_BITS-1:0]     mix_level;
    logic [7:0]              random_byte;
    logic [7:0]              read_data;
  } sound_result_t;

  logic clk_i;
  logic rst_ni;

  tnsg_in_if  in_if ();
  tnsg_out_if out_if ();

  tone_noise_sound_generator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_if),
    .out_item_o (out_if)
  );

  // Predicted generator state
  logic [7:0]              gen_regs [NUM_REGS];
  logic [PERIOD_BITS-1:0]  tone_count [NUM_CHANNELS];
  logic [LFSR_BITS-1:0]    noise_lfsr [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] toggle_bits;
  logic [NUM_CHANNELS-1:0] fired_bits;
  logic [NUM_CHANNELS-1:0] selected_bits;
  logic [ADDR_BITS-1:0]    play_addr;

  sound_result_t expected_results [$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned error_count;
  int unsigned quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // One XNOR LFSR step; the last channel uses the short tap set
  function automatic logic [LFSR_BITS-1:0] next_noise(logic [LFSR_BITS-1:0] s, int unsigned ch);
    logic fb;
    if (ch < NUM_CHANNELS - 1)
      fb = s[TAP_L0] ^ s[TAP_L1] ^ s[TAP_L2] ^ s[TAP_L3];
    else
      fb = s[TAP_S0] ^ s[TAP_S1] ^ s[TAP_S2] ^ s[TAP_S3];
    return {~fb, s[LFSR_BITS-1:1]};
  endfunction

  // Applies one item to the predicted state and returns the result it causes
  function automatic sound_result_t predict_item(logic [1:0] mode_code,
                                                 logic [REG_ADDR_W-1:0] addr,
                                                 logic [7:0] data);
    sound_result_t res;
    logic [PERIOD_BITS-1:0] period;
    logic [ADDR_BITS-1:0]   start_addr;
    logic [ADDR_BITS-1:0]   end_addr;
    logic [7:0]             mask;
    logic                   bit_out;
    int unsigned            c;
    res = '0;
    case (mode_code)
      MODE_TICK: begin
        // sample address moves before the channels
        start_addr = {gen_regs[REG_START_HI], gen_regs[REG_START_LO]};
        end_addr   = {gen_regs[REG_END_HI], gen_regs[REG_END_LO]};
        if (!gen_regs[REG_SAMPLE_CFG][0]) begin
          play_addr = '0;
        end else begin
          play_addr = play_addr + 16'd1;
          if (play_addr > end_addr) play_addr = start_addr;
        end
        mask          = gen_regs[REG_MASK];
        fired_bits    = '0;
        selected_bits = '0;
        for (c = 0; c < NUM_CHANNELS; c++) begin
          period = {gen_regs[2*c+1][3:0], gen_regs[2*c]};
          if (period != '0 && tone_count[c] >= period) begin
            tone_count[c] = '0;
            toggle_bits[c] = ~toggle_bits[c];
            noise_lfsr[c] = next_noise(noise_lfsr[c], c);
            fired_bits[c] = 1'b1;
          end else begin
            tone_count[c] = tone_count[c] + 1'b1;
          end
          if (mask[c+4])  bit_out = noise_lfsr[c][0];
          else if (mask[c]) bit_out = toggle_bits[c];
          else              bit_out = fired_bits[c];
          selected_bits[c] = bit_out;
        end
      end
      MODE_WRITE: gen_regs[addr] = data;
      MODE_READ:  res.read_data = gen_regs[addr];
      default: ;
    endcase
    res.channel_bits   = selected_bits;
    res.divided_bits   = toggle_bits;
    res.pulse_bits     = fired_bits;
    res.sample_address = play_addr;
    res.mix_level      = MIX_BITS'($countones(selected_bits) * gen_regs[REG_VOLUME]);
    res.random_byte    = noise_lfsr[0][7:0];
    return res;
  endfunction

  // Present one item and wait until the block takes it
  task automatic send_item(input logic [1:0] mode_code, input logic [REG_ADDR_W-1:0] addr,
                           input logic [7:0] data);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode_code;
    in_if.reg_addr   <= addr;
    in_if.write_data <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_results.push_back(predict_item(mode_code, addr, data));
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // Reset contents, unused item kind, first tick with all periods zero
  task automatic test_reset_and_unused_mode();
    send_item(MODE_READ, REG_END_HI, 8'h00);
    send_item(MODE_UNUSED, REG_VOLUME, 8'hff);
    send_item(MODE_TICK, 4'h0, 8'h00);
  endtask

  // Divided and pulse outputs, zero periods running free, volume seen on its own write
  task automatic test_tone_dividers();
    send_item(MODE_WRITE, REG_PERIOD_LO0, 8'h01);
    send_item(MODE_WRITE, REG_PERIOD_HI0, 8'hf0);
    send_item(MODE_WRITE, REG_MASK, 8'h0f);
    repeat (4) send_item(MODE_TICK, 4'hf, 8'hff);
    send_item(MODE_WRITE, REG_VOLUME, 8'hff);
    send_item(MODE_WRITE, REG_MASK, 8'h00);
    repeat (2) send_item(MODE_TICK, 4'h0, 8'h00);
  endtask

  // Noise select, longest period, sample address wrapping at 16 bits, pitch register
  task automatic test_noise_and_sample_wrap();
    send_item(MODE_WRITE, REG_PERIOD_LO3, 8'hff);
    send_item(MODE_WRITE, REG_PERIOD_HI3, 8'h0f);
    send_item(MODE_WRITE, REG_MASK, 8'hf0);
    send_item(MODE_WRITE, REG_START_LO, 8'hff);
    send_item(MODE_WRITE, REG_START_HI, 8'hff);
    send_item(MODE_WRITE, REG_SAMPLE_CFG, 8'h01);
    repeat (3) send_item(MODE_TICK, 4'h0, 8'h00);
    send_item(MODE_WRITE, REG_SAMPLE_PITCH, 8'hff);
    send_item(MODE_READ, REG_SAMPLE_PITCH, 8'h00);
  endtask

  // Mostly ticks, with writes biased to short periods and short sample loops
  task automatic test_random_traffic(input int unsigned count);
    int unsigned           pick;
    logic [REG_ADDR_W-1:0] addr;
    logic [7:0]            data;
    repeat (count) begin
      pick = $urandom_range(99);
      addr = REG_ADDR_W'($urandom_range(15));
      data = 8'($urandom);
      if (pick < 68) begin
        send_item(MODE_TICK, addr, data);
      end else if (pick < 88) begin
        if ($urandom_range(9) != 0) begin
          if (addr < REG_MASK) begin
            if (addr[0]) data = {data[7:4], 4'h0};
            else         data = 8'($urandom_range(12));
          end else if (addr == REG_START_HI || addr == REG_END_HI) begin
            data = 8'h00;
          end else if (addr == REG_START_LO || addr == REG_END_LO) begin
            data = 8'($urandom_range(40));
          end
        end
        send_item(MODE_WRITE, addr, data);
      end else if (pick < 97) begin
        send_item(MODE_READ, addr, data);
      end else begin
        send_item(MODE_UNUSED, addr, data);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Result side: compare each accepted result, then choose the next ready
  always @(posedge clk_i) begin
    sound_result_t exp_res;
    if (out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation pending");
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("channel_bits", exp_res.channel_bits, out_if.channel_bits);
        check_field("divided_bits", exp_res.divided_bits, out_if.divided_bits);
        check_field("pulse_bits", exp_res.pulse_bits, out_if.pulse_bits);
        check_field("sample_address", exp_res.sample_address, out_if.sample_address);
        check_field("mix_level", exp_res.mix_level, out_if.mix_level);
        check_field("random_byte", exp_res.random_byte, out_if.random_byte);
        check_field("read_data", exp_res.read_data, out_if.read_data);
      end
    end
    out_if.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < NUM_REGS; i++) gen_regs[i] = '0;
    for (i = 0; i < NUM_CHANNELS; i++) begin
      tone_count[i] = '0;
      noise_lfsr[i] = '0;
    end
    toggle_bits   = '0;
    fired_bits    = '0;
    selected_bits = '0;
    play_addr     = '0;
    error_count   = 0;
    quiet_cycles  = 0;
    set_idling(0, 0);

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_TICK;
    in_if.reg_addr   = '0;
    in_if.write_data = '0;
    out_if.ready     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_unused_mode();
    test_tone_dividers();
    test_noise_and_sample_wrap();

    // random traffic under each idling pattern
    set_idling(0, 0);
    test_random_traffic(ITEMS_PER_PHASE);
    set_idling(65, 0);
    test_random_traffic(ITEMS_PER_PHASE);
    set_idling(0, 65);
    test_random_traffic(ITEMS_PER_PHASE);
    set_idling(17, 17);
    test_random_traffic(ITEMS_PER_PHASE);
    in_if.valid <= 1'b0;

    // drain, then give stray results time to show up
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/tnsg_pkg.sv
src/tnsg_in_if.sv
src/tnsg_out_if.sv
src/tnsg_regs.sv
src/tnsg_channel.sv
src/tnsg_sample.sv
src/tone_noise_sound_generator_unit.sv
src/tnsg_checker.sv
dv/tb_tone_noise_sound_generator_unit.sv
